>>> hw/rtl/dbr_pkg.sv
`timescale 1ns / 1ps

package dbr_pkg;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned DT_W  = 16;

  localparam logic [CFG_W-1:0] GUARD_RESET  = 16'd80;
  localparam logic [CFG_W-1:0] REPEAT_RESET = 16'd300;

  // button modes, one-hot
  typedef enum logic [3:0] {
    MODE_LONG_OFF  = 4'b0001,
    MODE_SHORT_ON  = 4'b0010,
    MODE_LONG_ON   = 4'b0100,
    MODE_SHORT_OFF = 4'b1000
  } mode_e;

  typedef enum logic [0:0] {
    CFG_GUARD_TIME  = 1'b0,
    CFG_REPEAT_TIME = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic            btn1_pressed;
    logic            btn2_pressed;
    logic [DT_W-1:0] elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic push_event_1;
    logic push_event_2;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] guard_time;
    logic [CFG_W-1:0] repeat_time;
  } cfg_t;

endpackage

>>> hw/rtl/dbr_btn_step.sv
`timescale 1ns / 1ps

module dbr_btn_step import dbr_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  mode_e                 mode_i,
  input  logic [TIMER_BITS-1:0] timer_i,
  input  logic                  pressed_i,
  input  logic [DT_W-1:0]       dt_i,
  input  logic [TIMER_BITS-1:0] guard_i,
  input  logic [TIMER_BITS-1:0] repeat_i,
  output mode_e                 mode_o,
  output logic [TIMER_BITS-1:0] timer_o,
  output logic                  event_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > DT_W) ? TIMER_BITS : DT_W;

  logic [CMP_W-1:0] dt_w;
  logic [CMP_W-1:0] timer_w;
  logic [CMP_W-1:0] repeat_w;
  logic             timer_exp;
  logic             repeat_exp;
  logic [CMP_W-1:0] timer_sub;
  logic [CMP_W-1:0] repeat_sub;

  assign dt_w       = CMP_W'(dt_i);
  assign timer_w    = CMP_W'(timer_i);
  assign repeat_w   = CMP_W'(repeat_i);
  assign timer_exp  = (timer_w <= dt_w);
  assign repeat_exp = (repeat_w <= dt_w);
  // saturating subtractions, zero once expired
  assign timer_sub  = timer_exp ? '0 : (timer_w - dt_w);
  assign repeat_sub = repeat_exp ? '0 : (repeat_w - dt_w);

  always_comb begin
    mode_o  = mode_i;
    timer_o = timer_i;
    event_o = 1'b0;
    unique case (mode_i)
      MODE_LONG_OFF: begin
        if (pressed_i) begin
          mode_o  = MODE_SHORT_ON;
          timer_o = guard_i;
        end
      end
      MODE_SHORT_ON: begin
        if (timer_exp) begin
          event_o = 1'b1;
          mode_o  = MODE_LONG_ON;
          timer_o = repeat_sub[TIMER_BITS-1:0];
        end else begin
          timer_o = timer_sub[TIMER_BITS-1:0];
        end
      end
      MODE_LONG_ON: begin
        if (!pressed_i) begin
          mode_o  = MODE_SHORT_OFF;
          timer_o = guard_i;
        end else if (timer_exp) begin
          event_o = 1'b1;
          timer_o = repeat_sub[TIMER_BITS-1:0];
        end else begin
          timer_o = timer_sub[TIMER_BITS-1:0];
        end
      end
      MODE_SHORT_OFF: begin
        if (timer_exp) begin
          mode_o = MODE_LONG_OFF;
        end
        timer_o = timer_sub[TIMER_BITS-1:0];
      end
      default: begin
        mode_o = MODE_LONG_OFF;
      end
    endcase
  end

endmodule

>>> hw/rtl/dbr_core.sv
`timescale 1ns / 1ps

module dbr_core import dbr_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t res_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [CMP_W-1:0] TMAX_W = CMP_W'({TIMER_BITS{1'b1}});

  mode_e                 mode1_q, mode1_d, mode2_q, mode2_d;
  logic [TIMER_BITS-1:0] timer1_q, timer1_d, timer2_q, timer2_d;

  mode_e                 s1_mode, s2_mode;
  logic [TIMER_BITS-1:0] s1_timer, s2_timer;
  logic                  s1_ev, s2_ev;
  logic                  ev1, ev2;

  logic [CMP_W-1:0]      guard_w, repeat_w;
  logic [TIMER_BITS-1:0] guard_ld, repeat_ld;

  // register values clamp to the timer range
  assign guard_w   = CMP_W'(cfg_i.guard_time);
  assign repeat_w  = CMP_W'(cfg_i.repeat_time);
  assign guard_ld  = (guard_w > TMAX_W) ? {TIMER_BITS{1'b1}} : guard_w[TIMER_BITS-1:0];
  assign repeat_ld = (repeat_w > TMAX_W) ? {TIMER_BITS{1'b1}} : repeat_w[TIMER_BITS-1:0];

  dbr_btn_step #(.TIMER_BITS(TIMER_BITS)) u_step1 (
    .mode_i    (mode1_q),
    .timer_i   (timer1_q),
    .pressed_i (item_i.btn1_pressed),
    .dt_i      (item_i.elapsed_ticks),
    .guard_i   (guard_ld),
    .repeat_i  (repeat_ld),
    .mode_o    (s1_mode),
    .timer_o   (s1_timer),
    .event_o   (s1_ev)
  );

  dbr_btn_step #(.TIMER_BITS(TIMER_BITS)) u_step2 (
    .mode_i    (mode2_q),
    .timer_i   (timer2_q),
    .pressed_i (item_i.btn2_pressed),
    .dt_i      (item_i.elapsed_ticks),
    .guard_i   (guard_ld),
    .repeat_i  (repeat_ld),
    .mode_o    (s2_mode),
    .timer_o   (s2_timer),
    .event_o   (s2_ev)
  );

  // cross-coupling: button one copies first, then button two from the updated one
  always_comb begin
    mode1_d  = s1_mode;
    timer1_d = s1_timer;
    ev1      = s1_ev;
    if ((s1_mode == MODE_SHORT_ON) && s2_ev) begin
      ev1      = 1'b1;
      mode1_d  = s2_mode;
      timer1_d = s2_timer;
    end
    mode2_d  = s2_mode;
    timer2_d = s2_timer;
    ev2      = s2_ev;
    if ((s2_mode == MODE_SHORT_ON) && ev1) begin
      ev2      = 1'b1;
      mode2_d  = mode1_d;
      timer2_d = timer1_d;
    end
  end

  assign res_o.push_event_1 = ev1;
  assign res_o.push_event_2 = ev2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode1_q  <= MODE_LONG_OFF;
      mode2_q  <= MODE_LONG_OFF;
      timer1_q <= '0;
      timer2_q <= '0;
    end else if (step_i) begin
      mode1_q  <= mode1_d;
      mode2_q  <= mode2_d;
      timer1_q <= timer1_d;
      timer2_q <= timer2_d;
    end
  end

endmodule

>>> hw/rtl/dual_button_debounce_repeat_unit.sv
`timescale 1ns / 1ps

// Two-button debouncer with auto-repeat. Each input transaction is one poll carrying both
// button levels and the ticks since the previous poll; each poll yields exactly one result
// transaction with the two push events. One poll is accepted every clock cycle when the
// output side keeps up. The poll is held in the input register, the mode/timer update
// with compares and saturating subtracts is worked out from it, and the result register
// loads once the output side is ready. The user writes guard_time and repeat_time through
// the plain write port only while no poll is in flight; the block does not enforce this.
module dual_button_debounce_repeat_unit import dbr_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;
  out_t res;
  cfg_t cfg_q;

  logic out_ready;
  logic step;
  logic accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard_time  <= GUARD_RESET;
      cfg_q.repeat_time <= REPEAT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GUARD_TIME:  cfg_q.guard_time  <= cfg_wdata_i;
        CFG_REPEAT_TIME: cfg_q.repeat_time <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  dbr_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/dbr_checker.sv
`timescale 1ns / 1ps

module dbr_checker import dbr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input side only backs up behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // a fresh result shows up only after the edge that accepted its transaction
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without an accepted poll");

endmodule

bind dual_button_debounce_repeat_unit dbr_checker u_dbr_checker (.*);
